>>> src/graph_edge_weighter_unit_assert.svh
// ----------------------------------------------------------------------------
// Edge weighter assertion macros
// Shared property wrappers; the using module supplies clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef GRAPH_EDGE_WEIGHTER_UNIT_ASSERT_SVH
`define GRAPH_EDGE_WEIGHTER_UNIT_ASSERT_SVH

// same-cycle implication
`define GEW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("edge weighter: same-cycle check failed");

// next-cycle implication
`define GEW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("edge weighter: next-cycle check failed");

`endif

>>> src/gew_pkg.sv
// ----------------------------------------------------------------------------
// Edge weighter package
// Word types, register codes and the 2^-x fraction table for the design modules.
// ----------------------------------------------------------------------------
package gew_pkg;

    localparam int NODE_BITS       = 20;
    localparam int DIST_W          = 24;
    localparam int PROB_W          = 16;
    localparam int WEIGHT_W        = 16;
    localparam int VALUE_W         = 24;
    localparam int KARG_W          = 32;
    localparam int PARG_W          = 24;
    localparam int EXP_ARG_W       = 33;
    localparam int PEXP_ARG_W      = 25;
    localparam int EXP_TABLE_DEPTH = 256;
    localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
    localparam int EXP_N_LIMIT     = 17;
    localparam int LOG2E_Q16       = 94548;
    localparam int LN2_Q16         = 45426;
    localparam int WEIGHT_MAX      = 65535;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INV_BW    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BETA      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONF_TH   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CUTOFF    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_DAMAGE_EN = 3'd5;

    localparam logic [1:0] MODE_DAMAGE     = 2'd0;
    localparam logic [1:0] MODE_CUT_WEIGHT = 2'd1;
    localparam logic [1:0] MODE_CUT_RAW    = 2'd2;

    typedef enum logic [1:0] {
        KIND_WEIGHT,
        KIND_PENALTY,
        KIND_RAW
    } kind_t;

    typedef struct packed {
        logic [NODE_BITS-1:0] src_node;
        logic [NODE_BITS-1:0] dst_node;
        logic [DIST_W-1:0]    distance;
        logic [PROB_W-1:0]    conf_src;
        logic [PROB_W-1:0]    ancient_src;
        logic [PROB_W-1:0]    conf_dst;
        logic [PROB_W-1:0]    ancient_dst;
    } edge_in_t;

    typedef struct packed {
        logic [NODE_BITS-1:0] out_src;
        logic [NODE_BITS-1:0] out_dst;
        logic [VALUE_W-1:0]   edge_value;
    } edge_out_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [DIST_W-1:0] inv_bandwidth;
        logic [15:0]       penalty_beta;
        logic [PROB_W-1:0] confidence_threshold;
        logic [DIST_W-1:0] max_distance;
        logic              damage_enable;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        mode:                 MODE_DAMAGE,
        inv_bandwidth:        24'd65536,
        penalty_beta:         16'd256,
        confidence_threshold: 16'd32768,
        max_distance:         24'hFFFFFF,
        damage_enable:        1'b0
    };

    typedef struct packed {
        logic [NODE_BITS-1:0] src;
        logic [NODE_BITS-1:0] dst;
        logic [DIST_W-1:0]    distance;
        kind_t                kind;
    } tag_t;

    typedef struct packed {
        tag_t              tag;
        logic [PROB_W-1:0] diff;
    } work_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QUEUE_AW:0] count;
    } qstat_t;

    typedef logic [WEIGHT_W:0] exp_tbl_t [EXP_TABLE_DEPTH];

    // 2^(-i/depth) in Q1.16, rounded, from a 16-term series in Q32
    function automatic exp_tbl_t gew_build_tbl();
        exp_tbl_t    tbl;
        logic [63:0] t;
        logic [63:0] a;
        logic [63:0] a8;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] rnd;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++)
        begin
            t    = (64'(i) << 32) / EXP_TABLE_DEPTH;
            a    = (t * 64'(LN2_Q16)) >> 16;
            a8   = a >> 8;
            sum  = 64'h1_0000_0000;
            term = 64'h1_0000_0000;
            for (int k = 1; k <= 16; k++)
            begin
                term = ((term * a8) >> 24) / 64'(k);
                if (k[0])
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            rnd    = (sum + 64'd32768) >> 16;
            tbl[i] = rnd[WEIGHT_W:0];
        end
        return tbl;
    endfunction

    localparam exp_tbl_t EXP_TBL = gew_build_tbl();

    // exp(-x) back end: e = x*log2e in Q.16, table on the fraction, shift by the integer
    function automatic logic [WEIGHT_W-1:0] gew_exp_lookup(input logic [EXP_ARG_W-1:0] e);
        logic [EXP_ARG_W-17:0] n;
        logic [31:0]           scaled;
        logic [EXP_IDX_W-1:0]  idx;
        logic [WEIGHT_W:0]     v;
        logic [WEIGHT_W-1:0]   res;
        n      = e[EXP_ARG_W-1:16];
        scaled = 32'(e[15:0]) * 32'(EXP_TABLE_DEPTH);
        if (32'(scaled[31:16]) >= 32'(EXP_TABLE_DEPTH))
            idx = EXP_IDX_W'(EXP_TABLE_DEPTH - 1);
        else
            idx = scaled[16+EXP_IDX_W-1:16];
        v = EXP_TBL[idx] >> n[4:0];
        if (32'(n) >= 32'(EXP_N_LIMIT))
            res = '0;
        else if (32'(v) > 32'(WEIGHT_MAX))
            res = WEIGHT_W'(WEIGHT_MAX);
        else
            res = v[WEIGHT_W-1:0];
        return res;
    endfunction

endpackage

>>> src/gew_front.sv
// ----------------------------------------------------------------------------
// Edge weighter front end
// Classifies each incoming edge: drop, plain weight, damage penalty or raw.
// ----------------------------------------------------------------------------
module gew_front
(
    input  gew_pkg::cfg_t     cfg,
    input  gew_pkg::edge_in_t edge_word,
    output logic              keep,
    output gew_pkg::work_t    work
);

    logic                          cut;
    logic                          conf_ok;
    logic [gew_pkg::PROB_W-1:0]    diff;

    assign cut     = (edge_word.distance > cfg.max_distance) ||
                     (edge_word.src_node <= edge_word.dst_node);
    assign conf_ok = cfg.damage_enable &&
                     (edge_word.conf_src > cfg.confidence_threshold) &&
                     (edge_word.conf_dst > cfg.confidence_threshold);
    assign diff    = (edge_word.ancient_src > edge_word.ancient_dst)
                   ? edge_word.ancient_src - edge_word.ancient_dst
                   : edge_word.ancient_dst - edge_word.ancient_src;

    always_comb
    begin
        work.tag.src      = edge_word.src_node;
        work.tag.dst      = edge_word.dst_node;
        work.tag.distance = edge_word.distance;
        work.diff         = diff;
        work.tag.kind     = gew_pkg::KIND_WEIGHT;
        keep              = 1'b0;
        case (cfg.mode)
            gew_pkg::MODE_DAMAGE:
            begin
                keep          = 1'b1;
                work.tag.kind = conf_ok ? gew_pkg::KIND_PENALTY : gew_pkg::KIND_WEIGHT;
            end
            gew_pkg::MODE_CUT_WEIGHT:
            begin
                keep          = !cut;
                work.tag.kind = gew_pkg::KIND_WEIGHT;
            end
            gew_pkg::MODE_CUT_RAW:
            begin
                keep          = !cut;
                work.tag.kind = gew_pkg::KIND_RAW;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

endmodule

>>> src/gew_queue.sv
// ----------------------------------------------------------------------------
// Edge weighter work queue
// Short FIFO of classified edges between the front and the back end.
// ----------------------------------------------------------------------------
module gew_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  gew_pkg::work_t  push_word,
    input  logic            pop,
    output gew_pkg::work_t  head,
    output gew_pkg::qstat_t stat
);

    gew_pkg::work_t                   mem_reg [gew_pkg::QUEUE_DEPTH];
    logic [gew_pkg::QUEUE_AW-1:0]     wr_ptr_reg;
    logic [gew_pkg::QUEUE_AW-1:0]     wr_ptr_next;
    logic [gew_pkg::QUEUE_AW-1:0]     rd_ptr_reg;
    logic [gew_pkg::QUEUE_AW-1:0]     rd_ptr_next;
    logic [gew_pkg::QUEUE_AW:0]       count_reg;
    logic [gew_pkg::QUEUE_AW:0]       count_next;
    logic                             push_fire;
    logic                             pop_fire;

    assign stat.full  = (count_reg == (gew_pkg::QUEUE_AW + 1)'(gew_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;
    assign push_fire  = push && !stat.full;
    assign pop_fire   = pop && !stat.empty;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            if (wr_ptr_reg == gew_pkg::QUEUE_AW'(gew_pkg::QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop_fire)
        begin
            if (rd_ptr_reg == gew_pkg::QUEUE_AW'(gew_pkg::QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire)
            count_next = count_reg + 1'b1;
        else if (pop_fire && !push_fire)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
            mem_reg[wr_ptr_reg] <= push_word;
    end

endmodule

>>> src/gew_back.sv
// ----------------------------------------------------------------------------
// Edge weighter back end
// Five-stage exp pipeline: input register, kernel and penalty products, log2e
// scaling, table lookup and shift, combine into the output register.
// ----------------------------------------------------------------------------
module gew_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  gew_pkg::cfg_t      cfg,
    input  logic               q_valid,
    input  gew_pkg::work_t     q_word,
    output logic               pop,
    output logic               weight_valid,
    input  logic               weight_ready,
    output gew_pkg::edge_out_t weight_data
);

    logic                             adv;

    logic                             s1_valid_reg;
    logic                             s1_valid_next;
    gew_pkg::work_t                   s1_word_reg;

    logic                             s2_valid_reg;
    logic                             s2_valid_next;
    gew_pkg::tag_t                    s2_tag_reg;
    logic [gew_pkg::KARG_W-1:0]       s2_karg_reg;
    logic [gew_pkg::KARG_W-1:0]       s2_karg_next;
    logic [gew_pkg::PARG_W-1:0]       s2_parg_reg;
    logic [gew_pkg::PARG_W-1:0]       s2_parg_next;

    logic                             s3_valid_reg;
    logic                             s3_valid_next;
    gew_pkg::tag_t                    s3_tag_reg;
    logic [gew_pkg::EXP_ARG_W-1:0]    s3_ek_reg;
    logic [gew_pkg::EXP_ARG_W-1:0]    s3_ek_next;
    logic [gew_pkg::PEXP_ARG_W-1:0]   s3_ep_reg;
    logic [gew_pkg::PEXP_ARG_W-1:0]   s3_ep_next;

    logic                             s4_valid_reg;
    logic                             s4_valid_next;
    gew_pkg::tag_t                    s4_tag_reg;
    logic [gew_pkg::WEIGHT_W-1:0]     s4_wk_reg;
    logic [gew_pkg::WEIGHT_W-1:0]     s4_wk_next;
    logic [gew_pkg::WEIGHT_W-1:0]     s4_pk_reg;
    logic [gew_pkg::WEIGHT_W-1:0]     s4_pk_next;

    logic                             out_valid_reg;
    logic                             out_valid_next;
    gew_pkg::edge_out_t               out_data_reg;
    gew_pkg::edge_out_t               out_data_next;

    logic [47:0]                      kprod;
    logic [31:0]                      pprod;
    logic [48:0]                      ekprod;
    logic [40:0]                      epprod;
    logic [31:0]                      wprod;

    // whole pipeline moves together; only a held output word stalls it
    assign adv          = !out_valid_reg || weight_ready;
    assign pop          = adv;
    assign weight_valid = out_valid_reg;
    assign weight_data  = out_data_reg;

    assign kprod        = 48'(s1_word_reg.tag.distance) * 48'(cfg.inv_bandwidth);
    assign pprod        = 32'(s1_word_reg.diff) * 32'(cfg.penalty_beta);
    assign s2_karg_next = kprod[47:16];
    assign s2_parg_next = pprod[31:8];

    assign ekprod       = 49'(s2_karg_reg) * 49'(gew_pkg::LOG2E_Q16);
    assign epprod       = 41'(s2_parg_reg) * 41'(gew_pkg::LOG2E_Q16);
    assign s3_ek_next   = ekprod[48:16];
    assign s3_ep_next   = epprod[40:16];

    assign s4_wk_next   = gew_pkg::gew_exp_lookup(s3_ek_reg);
    assign s4_pk_next   = gew_pkg::gew_exp_lookup(gew_pkg::EXP_ARG_W'(s3_ep_reg));

    // round-to-nearest product; cannot exceed 65534
    assign wprod        = 32'(s4_wk_reg) * 32'(s4_pk_reg) + 32'd32768;

    always_comb
    begin
        out_data_next.out_src = s4_tag_reg.src;
        out_data_next.out_dst = s4_tag_reg.dst;
        case (s4_tag_reg.kind)
            gew_pkg::KIND_RAW:     out_data_next.edge_value = s4_tag_reg.distance;
            gew_pkg::KIND_PENALTY: out_data_next.edge_value = gew_pkg::VALUE_W'(wprod[31:16]);
            gew_pkg::KIND_WEIGHT:  out_data_next.edge_value = gew_pkg::VALUE_W'(s4_wk_reg);
            default:               out_data_next.edge_value = gew_pkg::VALUE_W'(s4_wk_reg);
        endcase
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s2_valid_next  = s2_valid_reg;
        s3_valid_next  = s3_valid_reg;
        s4_valid_next  = s4_valid_reg;
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            s1_valid_next  = q_valid;
            s2_valid_next  = s1_valid_reg;
            s3_valid_next  = s2_valid_reg;
            s4_valid_next  = s3_valid_reg;
            out_valid_next = s4_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            s4_valid_reg  <= s4_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_word_reg  <= q_word;
            s2_tag_reg   <= s1_word_reg.tag;
            s2_karg_reg  <= s2_karg_next;
            s2_parg_reg  <= s2_parg_next;
            s3_tag_reg   <= s2_tag_reg;
            s3_ek_reg    <= s3_ek_next;
            s3_ep_reg    <= s3_ep_next;
            s4_tag_reg   <= s3_tag_reg;
            s4_wk_reg    <= s4_wk_next;
            s4_pk_reg    <= s4_pk_next;
            out_data_reg <= out_data_next;
        end
    end

endmodule

>>> src/graph_edge_weighter_unit.sv
// ----------------------------------------------------------------------------
// Graph edge weighter
// Streams graph edges; gives each kept edge an exp-kernel weight or its raw distance.
// ----------------------------------------------------------------------------
// Usage:
//   edge_*   : input channel, one edge word per handshake.
//   weight_* : result channel, src/dst plus the weight (Q0.16) or, in mode 2,
//              the raw distance. Dropped edges give no word.
//   cfg_*    : register writes (index, data), always ready; write only when
//              the block is idle.
//   Throughput: one edge per cycle while the queue is not full. A kept edge
//   passes the queue and then the back-end pipeline: input register, product,
//   log2e scaling, table lookup and shift, combine, output register, which
//   drives weight_valid.
//   Reset: registers return to their defaults, queue and pipeline empty.
//   Receiver stall: the back end holds its output word and freezes; the front
//   keeps taking edges until the 4-entry queue fills, then drops edge_ready.
// ----------------------------------------------------------------------------
`include "graph_edge_weighter_unit_assert.svh"

module graph_edge_weighter_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               edge_valid,
    output logic                               edge_ready,
    input  gew_pkg::edge_in_t                  edge_data,
    output logic                               weight_valid,
    input  logic                               weight_ready,
    output gew_pkg::edge_out_t                 weight_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gew_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gew_pkg::CFG_DATA_W-1:0]     cfg_data
);

    gew_pkg::cfg_t   cfg_reg;
    gew_pkg::cfg_t   cfg_next;
    logic            front_keep;
    gew_pkg::work_t  front_work;
    gew_pkg::work_t  q_head;
    gew_pkg::qstat_t q_stat;
    logic            q_push;
    logic            q_pop;
    logic            back_pop;

    assign cfg_ready  = 1'b1;
    assign edge_ready = !q_stat.full;
    assign q_push     = edge_valid && edge_ready && front_keep;
    assign q_pop      = back_pop && !q_stat.empty;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                gew_pkg::CFG_MODE:      cfg_next.mode                 = cfg_data[1:0];
                gew_pkg::CFG_INV_BW:    cfg_next.inv_bandwidth        = cfg_data;
                gew_pkg::CFG_BETA:      cfg_next.penalty_beta         = cfg_data[15:0];
                gew_pkg::CFG_CONF_TH:   cfg_next.confidence_threshold = cfg_data[15:0];
                gew_pkg::CFG_CUTOFF:    cfg_next.max_distance         = cfg_data;
                gew_pkg::CFG_DAMAGE_EN: cfg_next.damage_enable        = cfg_data[0];
                default:                cfg_next                      = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= gew_pkg::CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    gew_front u_front
    (
        .cfg       (cfg_reg),
        .edge_word (edge_data),
        .keep      (front_keep),
        .work      (front_work)
    );

    gew_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (front_work),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    gew_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (!q_stat.empty),
        .q_word       (q_head),
        .pop          (back_pop),
        .weight_valid (weight_valid),
        .weight_ready (weight_ready),
        .weight_data  (weight_data)
    );

    `GEW_ASSERT_NOW(a_full_blocks_input, q_stat.full, !edge_ready)
    `GEW_ASSERT_NOW(a_no_pop_when_empty, q_stat.empty, !q_pop)
    `GEW_ASSERT_NEXT(a_count_tracks_push, q_push && !q_pop, q_stat.count == $past(q_stat.count) + 1'b1)

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Edge weighter testbench
// Streams directed and random edges through graph_edge_weighter_unit under a
// range of register settings. An in-bench kernel-weight predictor, which has
// its own copy of the registers, checks every output word in order. The bench
// also applies bursty input, receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import gew_pkg::*;

    localparam int          DRAIN_CYCLES    = 16;
    localparam int          WATCHDOG_LIMIT  = 5000;
    localparam int          LONG_HOLD       = 300;
    localparam int          RAND_PHASES     = 10;
    localparam int          ITEMS_PER_PHASE = 120;
    localparam int          MAX_REPORTS     = 10;
    localparam longint unsigned LOG2E_FIX   = 94548;
    localparam longint unsigned LN2_FIX     = 45426;
    localparam logic [15:0] SAT_WEIGHT      = 16'hFFFF;

    localparam logic [1:0]             MODE_UNUSED   = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI  = 3'd7;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_THIRD,
        RX_SPARSE
    } rx_style_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   edge_valid = 1'b0;
    logic                   edge_ready;
    edge_in_t               edge_data = '0;
    logic                   weight_valid;
    logic                   weight_ready = 1'b0;
    edge_out_t              weight_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // shadow registers
    logic [1:0]        reg_mode;
    logic [DIST_W-1:0] reg_inv_bw;
    logic [15:0]       reg_beta;
    logic [PROB_W-1:0] reg_conf_th;
    logic [DIST_W-1:0] reg_cutoff;
    logic              reg_damage_en;

    logic [16:0] pow2_frac [EXP_TABLE_DEPTH];

    edge_in_t  pending_edges [$];
    edge_out_t weights_due [$];
    edge_out_t predicted;
    edge_out_t want;

    int        edges_queued = 0;
    int        edges_taken = 0;
    int        results_seen = 0;
    int        fail_count = 0;
    int        burst_left = 0;
    int        gap_left = 0;
    int        hold_left = 0;
    int        rx_cycles = 0;
    int        idle_cycles = 0;
    bit        long_hold_done = 1'b0;
    rx_style_t rx_style = RX_OPEN;

    graph_edge_weighter_unit DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .edge_valid   (edge_valid),
        .edge_ready   (edge_ready),
        .edge_data    (edge_data),
        .weight_valid (weight_valid),
        .weight_ready (weight_ready),
        .weight_data  (weight_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // 2^(-i/depth) in Q1.16 from a 16-term series in Q32, rounded
    initial
    begin
        logic [63:0] t;
        logic [63:0] a;
        logic [63:0] sum;
        logic [63:0] term;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++)
        begin
            t    = (64'(i) << 32) / 64'(EXP_TABLE_DEPTH);
            a    = (t * LN2_FIX) >> 16;
            sum  = 64'd1 << 32;
            term = 64'd1 << 32;
            for (int k = 1; k <= 16; k++)
            begin
                term = ((term * (a >> 8)) >> 24) / 64'(k);
                sum  = k[0] ? sum - term : sum + term;
            end
            pow2_frac[i] = 17'((sum + 64'd32768) >> 16);
        end
    end

    // exp(-x) for x in Q.16, as 2^-(x*log2e)
    function automatic logic [15:0] neg_exp_q16(input logic [63:0] x);
        logic [63:0] ex;
        logic [63:0] n;
        int          idx;
        logic [16:0] v;
        ex  = (x * LOG2E_FIX) >> 16;
        n   = ex >> 16;
        idx = int'((64'(ex[15:0]) * 64'(EXP_TABLE_DEPTH)) >> 16);
        if (n >= 64'd17)
            return '0;
        v = pow2_frac[idx] >> n;
        return (v > 17'(SAT_WEIGHT)) ? SAT_WEIGHT : v[15:0];
    endfunction

    // returns 1 when the edge is kept, with its output word
    function automatic logic weigh_edge(input edge_in_t e, output edge_out_t r);
        logic [15:0] w;
        logic [15:0] p;
        logic [63:0] diff;
        logic [63:0] prod;
        r.out_src    = e.src_node;
        r.out_dst    = e.dst_node;
        r.edge_value = '0;
        if (reg_mode == MODE_UNUSED)
            return 1'b0;
        if (reg_mode != MODE_DAMAGE &&
            (e.distance > reg_cutoff || e.src_node <= e.dst_node))
            return 1'b0;
        if (reg_mode == MODE_CUT_RAW)
        begin
            r.edge_value = e.distance;
            return 1'b1;
        end
        w = neg_exp_q16((64'(e.distance) * 64'(reg_inv_bw)) >> 16);
        if (reg_mode == MODE_DAMAGE && reg_damage_en &&
            e.conf_src > reg_conf_th && e.conf_dst > reg_conf_th)
        begin
            diff = (e.ancient_src > e.ancient_dst) ? 64'(e.ancient_src - e.ancient_dst)
                                                   : 64'(e.ancient_dst - e.ancient_src);
            p    = neg_exp_q16((diff * 64'(reg_beta)) >> 8);
            prod = (64'(w) * 64'(p) + 64'd32768) >> 16;
            w    = (prod > 64'(SAT_WEIGHT)) ? SAT_WEIGHT : prod[15:0];
        end
        r.edge_value = VALUE_W'(w);
        return 1'b1;
    endfunction

    function automatic edge_in_t make_edge(input logic [NODE_BITS-1:0] src,
                                           input logic [NODE_BITS-1:0] dst,
                                           input logic [DIST_W-1:0]    dist_in,
                                           input logic [PROB_W-1:0]    cs,
                                           input logic [PROB_W-1:0]    as_,
                                           input logic [PROB_W-1:0]    cd,
                                           input logic [PROB_W-1:0]    ad);
        edge_in_t e;
        e.src_node    = src;
        e.dst_node    = dst;
        e.distance    = dist_in;
        e.conf_src    = cs;
        e.ancient_src = as_;
        e.conf_dst    = cd;
        e.ancient_dst = ad;
        return e;
    endfunction

    // confidence near, above or anywhere around the threshold
    function automatic logic [PROB_W-1:0] conf_pick();
        case ($urandom_range(0, 3))
            0: return PROB_W'(reg_conf_th + $urandom_range(0, 2) - 1);
            1: return PROB_W'($urandom);
            default:
                if (reg_conf_th == '1)
                    return PROB_W'($urandom);
                else
                    return PROB_W'($urandom_range(reg_conf_th + 1, 16'hFFFF));
        endcase
    endfunction

    task automatic offer(input edge_in_t e);
        pending_edges = {pending_edges, e};
        edges_queued++;
    endtask

    // called at a clock edge; returns after the write is taken
    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0]  val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MODE:      reg_mode      = val[1:0];
            CFG_INV_BW:    reg_inv_bw    = val[DIST_W-1:0];
            CFG_BETA:      reg_beta      = val[15:0];
            CFG_CONF_TH:   reg_conf_th   = val[PROB_W-1:0];
            CFG_CUTOFF:    reg_cutoff    = val[DIST_W-1:0];
            CFG_DAMAGE_EN: reg_damage_en = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // wait for every edge to be taken and every weight to come back
    task automatic drain();
        while (edges_taken != edges_queued || weights_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // edge driver: bursts with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            edge_valid <= 1'b0;
        end
        else
        begin
            if (edge_valid && edge_ready)
            begin
                edges_taken++;
                if (weigh_edge(edge_data, predicted))
                    weights_due = {weights_due, predicted};
            end
            if (!edge_valid || edge_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    edge_valid <= 1'b0;
                end
                else if (pending_edges.size() > 0)
                begin
                    edge_data  <= pending_edges.pop_front();
                    edge_valid <= 1'b1;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                begin
                    edge_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: randomly chosen stall styles, one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            weight_ready <= 1'b0;
        end
        else
        begin
            rx_cycles++;
            if (hold_left > 0)
            begin
                hold_left--;
                weight_ready <= 1'b0;
            end
            else if (!long_hold_done && results_seen >= 400 && pending_edges.size() > 32)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
                weight_ready <= 1'b0;
            end
            else
            begin
                if (rx_cycles % 96 == 0)
                    rx_style = rx_style_t'($urandom_range(0, 3));
                case (rx_style)
                    RX_OPEN:   weight_ready <= 1'b1;
                    RX_COIN:   weight_ready <= 1'($urandom_range(0, 1));
                    RX_THIRD:  weight_ready <= (rx_cycles % 3 == 0);
                    default:   weight_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && weight_valid && weight_ready)
        begin
            results_seen++;
            if (weights_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("ERROR: unexpected word src %0h dst %0h value %0h",
                             weight_data.out_src, weight_data.out_dst,
                             weight_data.edge_value);
            end
            else
            begin
                want = weights_due.pop_front();
                if (weight_data.out_src !== want.out_src ||
                    weight_data.out_dst !== want.out_dst ||
                    weight_data.edge_value !== want.edge_value)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("ERROR: expected %0h->%0h value %0h, got %0h->%0h value %0h",
                                 want.out_src, want.out_dst, want.edge_value,
                                 weight_data.out_src, weight_data.out_dst,
                                 weight_data.edge_value);
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((edge_valid && edge_ready) || (weight_valid && weight_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        logic [1:0]           m;
        logic                 den;
        logic [DIST_W-1:0]    inv;
        logic [DIST_W-1:0]    cut;
        logic [15:0]          beta;
        logic [PROB_W-1:0]    th;
        logic [NODE_BITS-1:0] na;
        logic [NODE_BITS-1:0] nb;
        logic [NODE_BITS-1:0] swap;
        bit                   well;
        edge_in_t             e;

        reg_mode      = MODE_DAMAGE;
        reg_inv_bw    = 24'd65536;
        reg_beta      = 16'd256;
        reg_conf_th   = 16'd32768;
        reg_cutoff    = 24'hFFFFFF;
        reg_damage_en = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: damage data off
        offer(make_edge('0, '0, '0, '0, '0, '0, '0));
        offer(make_edge('1, '1, '1, '1, '1, '1, '1));
        offer(make_edge(20'h00010, 20'h00020, 24'h010000, 16'hFFFF, 16'h0000,
                        16'hFFFF, 16'hFFFF));
        offer(make_edge(20'h12345, 20'h00001, 24'h00B172, 16'h8001, 16'h4000,
                        16'h8001, 16'hC000));
        drain();

        // penalty only when both confidences are strictly above threshold
        cfg_write(CFG_DAMAGE_EN, 24'd1);
        offer(make_edge(20'h00003, 20'h00007, 24'h008000, 16'hFFFF, 16'h0000,
                        16'h8001, 16'hFFFF));
        offer(make_edge(20'h00003, 20'h00007, 24'h004000, 16'h8000, 16'h1234,
                        16'hFFFF, 16'h4321));
        offer(make_edge(20'h00003, 20'h00007, 24'h004000, 16'hFFFF, 16'h1234,
                        16'h8000, 16'h4321));
        offer(make_edge(20'h00009, 20'h00002, 24'h001000, 16'h8001, 16'h5555,
                        16'h8001, 16'h5555));
        drain();

        cfg_write(CFG_BETA, 24'h00FFFF);
        cfg_write(CFG_CONF_TH, 24'd0);
        offer(make_edge(20'h00400, 20'h00500, 24'h000100, 16'h0001, 16'h7FFF,
                        16'h0001, 16'h8000));
        offer(make_edge(20'h00400, 20'h00500, 24'h000100, 16'h0000, 16'h7FFF,
                        16'h0000, 16'h8000));
        drain();

        // zero reciprocal bandwidth: kernel weight saturates
        cfg_write(CFG_INV_BW, 24'd0);
        offer(make_edge(20'h00011, 20'h00022, 24'hFFFFFF, 16'h0001, 16'h0000,
                        16'h0001, 16'h0000));
        drain();

        // cutoff-filtered weight
        cfg_write(CFG_MODE, CFG_DATA_W'(MODE_CUT_WEIGHT));
        cfg_write(CFG_INV_BW, 24'd65536);
        cfg_write(CFG_CUTOFF, 24'h020000);
        offer(make_edge(20'h00100, 20'h000FF, 24'h020000, '0, '0, '0, '0));
        offer(make_edge(20'h00100, 20'h000FF, 24'h020001, '0, '0, '0, '0));
        offer(make_edge(20'h00100, 20'h00100, 24'h000100, '0, '0, '0, '0));
        offer(make_edge(20'h000FF, 20'h00100, 24'h000100, '0, '0, '0, '0));
        offer(make_edge(20'hFFFFF, 20'h00000, 24'h000000, '1, '1, '1, '1));
        drain();

        // cutoff-filtered raw distance
        cfg_write(CFG_MODE, CFG_DATA_W'(MODE_CUT_RAW));
        offer(make_edge(20'h54321, 20'h12345, 24'h020000, '0, '0, '0, '0));
        offer(make_edge(20'h54321, 20'h54321, 24'h000010, '0, '0, '0, '0));
        offer(make_edge(20'h54321, 20'h12345, 24'h020001, '0, '0, '0, '0));
        drain();

        // all-ones write lands as the unused mode: every edge dropped
        cfg_write(CFG_MODE, '1);
        offer(make_edge(20'h00002, 20'h00001, 24'h000000, '0, '0, '0, '0));
        offer(make_edge(20'hFFFFF, 20'h00000, 24'h000001, '1, '1, '1, '1));
        drain();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case ((p < 6) ? p % 3 : $urandom_range(0, 2))
                0:       m = MODE_DAMAGE;
                1:       m = MODE_CUT_WEIGHT;
                default: m = MODE_CUT_RAW;
            endcase
            den  = ($urandom_range(0, 3) != 0);
            inv  = DIST_W'($urandom) >> $urandom_range(4, 16);
            beta = 16'($urandom) >> $urandom_range(0, 15);
            th   = PROB_W'($urandom);
            cut  = DIST_W'($urandom) >> $urandom_range(0, 8);
            case (p)
                0:
                begin
                    den  = 1'b1;
                    beta = 16'hFFFF;
                    th   = '0;
                end
                1:
                begin
                    inv = '1;
                    cut = '0;
                end
                2:
                begin
                    inv = 24'd1;
                    cut = '1;
                end
                3:
                begin
                    den  = 1'b1;
                    beta = '0;
                    th   = 16'hFFFE;
                end
                4: cut = '1;
                6: den = 1'b0;
                9: th = '1;
                default: ;
            endcase
            cfg_write(CFG_MODE, CFG_DATA_W'(m));
            cfg_write(CFG_INV_BW, inv);
            cfg_write(CFG_BETA, CFG_DATA_W'(beta));
            cfg_write(CFG_CONF_TH, CFG_DATA_W'(th));
            cfg_write(CFG_CUTOFF, cut);
            cfg_write(CFG_DAMAGE_EN, CFG_DATA_W'(den));
            // indexes past the register list must leave everything alone
            cfg_write(CFG_SPARE_LO, CFG_DATA_W'($urandom));
            cfg_write(CFG_SPARE_HI, CFG_DATA_W'($urandom));

            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                well = ($urandom_range(0, 9) < 8);
                na   = NODE_BITS'($urandom);
                nb   = NODE_BITS'($urandom);
                if (well)
                begin
                    if (na < nb)
                    begin
                        swap = na;
                        na   = nb;
                        nb   = swap;
                    end
                    else if (na == nb)
                    begin
                        if (na == '0)
                            na = NODE_BITS'(1);
                        else
                            nb = na - 1'b1;
                    end
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    nb = na;
                end
                e.src_node = na;
                e.dst_node = nb;
                case ($urandom_range(0, 9))
                    0: e.distance = reg_cutoff;
                    1: e.distance = reg_cutoff + 1'b1;
                    2: e.distance = '0;
                    3: e.distance = '1;
                    default:
                        if (well)
                            e.distance = DIST_W'($urandom_range(0, reg_cutoff)
                                                 >> $urandom_range(0, 16));
                        else
                            e.distance = DIST_W'($urandom) >> $urandom_range(0, 23);
                endcase
                e.conf_src    = conf_pick();
                e.conf_dst    = conf_pick();
                e.ancient_src = PROB_W'($urandom);
                e.ancient_dst = $urandom_range(0, 1) ? PROB_W'($urandom)
                              : PROB_W'(e.ancient_src + $urandom_range(0, 64) - 32);
                offer(e);
            end
            drain();
        end

        if (fail_count == 0 && weights_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
